// ----- src/psrt_pkg.sv -----
// ----------------------------------------------------------------------------
// psrt_pkg
// Shared types and constants of the 2D point scale, rotate and translate block.
// ----------------------------------------------------------------------------
package psrt_pkg;

  // CORDIC datapath widths: x/y in Q30, z in Q24 degrees.
  localparam int XW = 34;
  localparam int ZW = 34;
  localparam int ACC_W = 96;

  localparam logic [16:0] FULL_TURN     = 17'd92160;
  localparam logic [16:0] QUARTER_TURN  = 17'd23040;
  localparam logic [16:0] HALF_TURN     = 17'd46080;
  localparam logic [16:0] THREE_QUARTER = 17'd69120;

  localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [XW-1:0] ONE_Q30  = 34'sd1073741824;

  localparam longint unsigned RAD2DEG_Q40 = 64'd62997375797119;

  // Configuration register indexes.
  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_ROT     = 3'd2;
  localparam logic [2:0] REG_SCALE_X = 3'd3;
  localparam logic [2:0] REG_SCALE_Y = 3'd4;

  // Item carried along the CORDIC chain.
  typedef struct packed {
    logic                 vld;
    logic                 flip;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [31:0]   lx;
    logic signed [31:0]   ly;
  } cell_t;

  // Q62 sums, rounding offset included, handed to the output stage.
  typedef struct packed {
    logic              vld;
    logic [ACC_W-1:0]  tot_x;
    logic [ACC_W-1:0]  tot_y;
  } res_t;

  // atan(2^-i) in Q24 degrees, evaluated at elaboration.
  function automatic longint stage_angle(input int i);
    longint unsigned t;
    case (i)
      0: return 64'd754974720;
      1: return 64'd445687602;
      2: return 64'd235489088;
      3: return 64'd119537938;
      default: begin
        t = (RAD2DEG_Q40 >> i) - (RAD2DEG_Q40 >> (3 * i)) / 3
          + (RAD2DEG_Q40 >> (5 * i)) / 5;
        return longint'((t + 64'd32768) >> 16);
      end
    endcase
  endfunction

endpackage

// ----- src/psrt_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// psrt_cordic_cell
// One CORDIC rotation-mode iteration with a fixed shift, registered.
// ----------------------------------------------------------------------------
module psrt_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  psrt_pkg::cell_t d_i,
  output psrt_pkg::cell_t q_o
);
  import psrt_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = ZW'(stage_angle(IDX));

  logic  vld_r;
  cell_t data_r;
  cell_t data_nxt;

  always_comb begin
    data_nxt     = d_i;
    data_nxt.vld = 1'b0;
    if (!d_i.z[ZW-1]) begin
      data_nxt.x = d_i.x - (d_i.y >>> IDX);
      data_nxt.y = d_i.y + (d_i.x >>> IDX);
      data_nxt.z = d_i.z - ANGLE;
    end else begin
      data_nxt.x = d_i.x + (d_i.y >>> IDX);
      data_nxt.y = d_i.y - (d_i.x >>> IDX);
      data_nxt.z = d_i.z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= d_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  always_comb begin
    q_o     = data_r;
    q_o.vld = vld_r;
  end

endmodule

// ----- src/psrt_combine.sv -----
// ----------------------------------------------------------------------------
// psrt_combine
// Clamps sine and cosine, scales the point and forms the rotated, translated
// sums in Q62 over four pipeline stages.
// ----------------------------------------------------------------------------
module psrt_combine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  psrt_pkg::cell_t    d_i,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  output psrt_pkg::res_t     q_o
);
  import psrt_pkg::*;

  // Stage valid bits: clamp/scale, partial products, sums/differences, totals.
  logic p_vld_r, m_vld_r, a_vld_r, b_vld_r;

  logic signed [XW-1:0] cx, cy;
  logic signed [31:0]   cs_nxt, sn_nxt;
  logic signed [63:0]   sx_nxt, sy_nxt;
  logic signed [31:0]   cs_r, sn_r;
  logic signed [63:0]   sx_r, sy_r;

  // Partial products: the low word of sx/sy is unsigned, the high word signed.
  logic signed [64:0] xc_lo_r, ys_lo_r, xs_lo_r, yc_lo_r;
  logic signed [63:0] xc_hi_r, ys_hi_r, xs_hi_r, yc_hi_r;

  logic [65:0] lo_x_r, lo_y_r;
  logic [64:0] hi_x_r, hi_y_r;

  logic [ACC_W-1:0] tot_x_r, tot_y_r;

  always_comb begin
    cx = d_i.x;
    cy = d_i.y;
    if (d_i.x > ONE_Q30) cx = ONE_Q30;
    if (d_i.x < -ONE_Q30) cx = -ONE_Q30;
    if (d_i.y > ONE_Q30) cy = ONE_Q30;
    if (d_i.y < -ONE_Q30) cy = -ONE_Q30;
    cs_nxt = d_i.flip ? -cx[31:0] : cx[31:0];
    sn_nxt = d_i.flip ? -cy[31:0] : cy[31:0];
    sx_nxt = d_i.lx * scale_x;
    sy_nxt = d_i.ly * scale_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      m_vld_r <= 1'b0;
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (adv) begin
      p_vld_r <= d_i.vld;
      m_vld_r <= p_vld_r;
      a_vld_r <= m_vld_r;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs_r <= cs_nxt;
      sn_r <= sn_nxt;
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;

      xc_lo_r <= $signed({1'b0, sx_r[31:0]}) * cs_r;
      ys_lo_r <= $signed({1'b0, sy_r[31:0]}) * sn_r;
      xs_lo_r <= $signed({1'b0, sx_r[31:0]}) * sn_r;
      yc_lo_r <= $signed({1'b0, sy_r[31:0]}) * cs_r;
      xc_hi_r <= $signed(sx_r[63:32]) * cs_r;
      ys_hi_r <= $signed(sy_r[63:32]) * sn_r;
      xs_hi_r <= $signed(sx_r[63:32]) * sn_r;
      yc_hi_r <= $signed(sy_r[63:32]) * cs_r;

      lo_x_r <= {xc_lo_r[64], xc_lo_r} - {ys_lo_r[64], ys_lo_r};
      lo_y_r <= {xs_lo_r[64], xs_lo_r} + {yc_lo_r[64], yc_lo_r};
      hi_x_r <= {xc_hi_r[63], xc_hi_r} - {ys_hi_r[63], ys_hi_r};
      hi_y_r <= {xs_hi_r[63], xs_hi_r} + {yc_hi_r[63], yc_hi_r};

      // Half an output LSB is added here so the output stage only truncates.
      tot_x_r <= {hi_x_r[63:0], 32'b0} + {{30{lo_x_r[65]}}, lo_x_r}
               + {{18{pos_x[31]}}, pos_x, 46'b0} + (96'd1 << 45);
      tot_y_r <= {hi_y_r[63:0], 32'b0} + {{30{lo_y_r[65]}}, lo_y_r}
               + {{18{pos_y[31]}}, pos_y, 46'b0} + (96'd1 << 45);
    end
  end

  always_comb begin
    q_o.vld   = b_vld_r;
    q_o.tot_x = tot_x_r;
    q_o.tot_y = tot_y_r;
  end

endmodule

// ----- src/point_scale_rotate_translate_2d.sv -----
// ----------------------------------------------------------------------------
// point_scale_rotate_translate_2d
// Scales a Q16.16 point per axis, rotates it with a CORDIC chain and adds
// the configured position, saturating the result.
// ----------------------------------------------------------------------------
//  Channel | Handshake          | Payload
//  --------+--------------------+-----------------------------------------
//  in      | in_valid/in_ready  | in_local_x, in_local_y
//  out     | out_valid/out_ready| out_global_x, out_global_y, out_saturated
//  cfg     | cfg_we             | cfg_idx, cfg_wdata
//
// One item per cycle is accepted unless the output stalls; an item passes
// the entry register, CORDIC cells, combine stages and output register.
// The whole pipeline advances together whenever the output register is
// empty or its transfer completes; a stalled output freezes every stage.
// Synchronous reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module point_scale_rotate_translate_2d #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_local_x,
  input  logic signed [31:0] in_local_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_global_x,
  output logic signed [31:0] out_global_y,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_wdata
);
  import psrt_pkg::*;

  localparam int NUM_STAGES = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  logic signed [31:0] pos_x_r, pos_y_r, scale_x_r, scale_y_r;
  logic [16:0]        rot_r;

  logic adv;

  logic [16:0] ang;
  logic [17:0] z_deg;
  logic        flip_nxt;
  logic        e_vld_r;
  cell_t       e_data_r;
  cell_t       chain [NUM_STAGES+1];
  res_t        res;

  logic               out_valid_r;
  logic signed [31:0] gx_r, gy_r, gx_nxt, gy_nxt;
  logic               sat_r, sat_x, sat_y;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      rot_r     <= '0;
      scale_x_r <= 32'sd65536;
      scale_y_r <= 32'sd65536;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_POS_X:   pos_x_r   <= cfg_wdata;
        REG_POS_Y:   pos_y_r   <= cfg_wdata;
        REG_ROT:     rot_r     <= cfg_wdata[16:0];
        REG_SCALE_X: scale_x_r <= cfg_wdata;
        REG_SCALE_Y: scale_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Fold the angle into [-90, 90] degrees; the middle half turn flips signs.
  always_comb begin
    ang      = (rot_r >= FULL_TURN) ? rot_r - FULL_TURN : rot_r;
    flip_nxt = 1'b0;
    if (ang <= QUARTER_TURN) begin
      z_deg = {1'b0, ang};
    end else if (ang < THREE_QUARTER) begin
      z_deg    = {1'b0, ang} - {1'b0, HALF_TURN};
      flip_nxt = 1'b1;
    end else begin
      z_deg = {1'b0, ang} - {1'b0, FULL_TURN};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_data_r.vld  <= 1'b0;
      e_data_r.flip <= flip_nxt;
      e_data_r.x    <= GAIN_Q30;
      e_data_r.y    <= '0;
      e_data_r.z    <= {z_deg, 16'b0};
      e_data_r.lx   <= in_local_x;
      e_data_r.ly   <= in_local_y;
    end
  end

  always_comb begin
    chain[0]     = e_data_r;
    chain[0].vld = e_vld_r;
  end

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
    psrt_cordic_cell #(
      .IDX (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .d_i   (chain[g]),
      .q_o   (chain[g+1])
    );
  end

  psrt_combine u_combine (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .d_i     (chain[NUM_STAGES]),
    .scale_x (scale_x_r),
    .scale_y (scale_y_r),
    .pos_x   (pos_x_r),
    .pos_y   (pos_y_r),
    .q_o     (res)
  );

  // The rounded value fits 32 bits only if bits 95..77 are all equal.
  always_comb begin
    sat_x  = !((&res.tot_x[ACC_W-1:77]) || !(|res.tot_x[ACC_W-1:77]));
    sat_y  = !((&res.tot_y[ACC_W-1:77]) || !(|res.tot_y[ACC_W-1:77]));
    gx_nxt = res.tot_x[77:46];
    gy_nxt = res.tot_y[77:46];
    if (sat_x) gx_nxt = res.tot_x[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    if (sat_y) gy_nxt = res.tot_y[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gx_r  <= gx_nxt;
      gy_r  <= gy_nxt;
      sat_r <= sat_x || sat_y;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_global_x  = gx_r;
  assign out_global_y  = gy_r;
  assign out_saturated = sat_r;

endmodule

// ----- src/psrt_checker.sv -----
// ----------------------------------------------------------------------------
// psrt_port_checker
// Port-level checks of the point transform, bound to the top level.
// ----------------------------------------------------------------------------
module psrt_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_global_x,
  input logic signed [31:0] out_global_y,
  input logic               out_saturated
);

  // A waiting result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_global_x)
      && $stable(out_global_y) && $stable(out_saturated))
    else $error("result changed while stalled");

  // A stalled output stops the input side too.
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");

  // A free output stage always lets the next item in.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A clamped result shows a limit value on at least one coordinate.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_global_x == 32'sh7FFF_FFFF || out_global_x == 32'sh8000_0000
      || out_global_y == 32'sh7FFF_FFFF || out_global_y == 32'sh8000_0000)
    else $error("saturation flag without a limit value");

endmodule

bind point_scale_rotate_translate_2d psrt_port_checker u_psrt_port_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_global_x  (out_global_x),
  .out_global_y  (out_global_y),
  .out_saturated (out_saturated)
);
